FILE: rtl/core/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg
// Shared constants, types and port groups for the integer array sorter.
// ----------------------------------------------------------------------------
package ias_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int STORE_DEPTH = 64;

   localparam int ELEM_WIDTH  = (VALUE_WIDTH < DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
   localparam int CAPACITY    = (MAX_ITEMS < STORE_DEPTH) ? MAX_ITEMS : STORE_DEPTH;
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
   localparam int COUNT_WIDTH = ADDR_WIDTH + 1;
   localparam int RANGE_WIDTH = 2 * ADDR_WIDTH;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic [ADDR_WIDTH-1:0]        addr_type;
   typedef logic [COUNT_WIDTH-1:0]       count_type;

   // One access slot on the element memory.
   typedef struct packed {
      logic     we;
      addr_type waddr;
      elem_type wdata;
      addr_type raddr;
   } mem_req_type;

   typedef struct packed {
      logic      start;
      count_type count;
   } sort_cmd_type;

endpackage

FILE: rtl/core/integer_array_sort.sv
// ----------------------------------------------------------------------------
// integer_array_sort
// Batch sorter: collects signed values, sorts them and streams them out.
// ----------------------------------------------------------------------------
// Requests are written into a 64-entry element memory at one per cycle until
// a request marked last arrives; requests beyond capacity are dropped and the
// batch is flagged truncated. The batch is then sorted in place by a quicksort
// sequencer with a range stack in a second memory. All work goes through the
// single read and write port of the element memory, which comparisons,
// exchanges and the overhead of each partition share; sorting is slowest for
// adversarial orderings such as a batch of equal values. Results then leave
// one at a time: each is read from the element memory and offered only once
// the previous result has been taken. New requests are taken only between
// batches, but the next batch may start loading while the final result still
// waits on the output. No clearing pass is needed after reset.
module integer_array_sort (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_value,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sorted_value,
   output logic               rsp_last_result,
   output logic               rsp_truncated
);

   localparam logic [2:0] P_LOAD    = 3'd0;
   localparam logic [2:0] P_START   = 3'd1;
   localparam logic [2:0] P_SORT    = 3'd2;
   localparam logic [2:0] P_EMIT_RD = 3'd3;
   localparam logic [2:0] P_EMIT_WT = 3'd4;

   localparam int AW = ias_pkg::ADDR_WIDTH;
   localparam int CW = ias_pkg::COUNT_WIDTH;
   localparam int DW = ias_pkg::DATA_WIDTH;
   localparam int EW = ias_pkg::ELEM_WIDTH;

   logic [2:0]            phase_ff, phase_in;
   ias_pkg::count_type    count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   ias_pkg::addr_type     emit_ff, emit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ias_pkg::elem_type     rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_trunc_ff, rsp_trunc_in;

   logic                  req_accept;
   logic                  has_room;
   logic                  slot_free;
   logic                  emit_last;
   ias_pkg::sort_cmd_type sort_cmd;
   logic                  sort_done;
   ias_pkg::mem_req_type  sort_req;
   ias_pkg::mem_req_type  mem_req;
   ias_pkg::elem_type     mem_rdata;

   ias_ram #(
      .DEPTH(ias_pkg::STORE_DEPTH),
      .WIDTH(EW)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.raddr),
      .rd_data (mem_rdata)
   );

   ias_qsort u_qsort (
      .clock     (clock),
      .reset     (reset),
      .sort_cmd  (sort_cmd),
      .sort_done (sort_done),
      .mem_req   (sort_req),
      .mem_rdata (mem_rdata)
   );

   assign req_ready  = (phase_ff == P_LOAD);
   assign req_accept = req_valid && req_ready;
   assign has_room   = (count_ff < CW'(ias_pkg::CAPACITY));
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last  = ({1'b0, emit_ff} + CW'(1) == count_ff);

   assign sort_cmd.start = (phase_ff == P_START);
   assign sort_cmd.count = count_ff;

   always_comb begin
      mem_req = '0;
      unique case (phase_ff)
         P_LOAD: begin
            mem_req.we    = req_accept && has_room;
            mem_req.waddr = count_ff[AW-1:0];
            mem_req.wdata = req_value[EW-1:0];
         end
         P_START, P_SORT: begin
            mem_req = sort_req;
         end
         P_EMIT_RD, P_EMIT_WT: begin
            mem_req.raddr = emit_ff;
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      unique case (phase_ff)
         P_LOAD: begin
            if (req_accept) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_item) begin
                  phase_in = P_START;
               end
            end
         end
         P_START, P_SORT: begin
            if (sort_done) begin
               emit_in  = '0;
               phase_in = P_EMIT_RD;
            end else begin
               phase_in = P_SORT;
            end
         end
         P_EMIT_RD: begin
            phase_in = P_EMIT_WT;
         end
         P_EMIT_WT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mem_rdata;
               rsp_last_in  = emit_last;
               rsp_trunc_in = ovf_ff;
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  phase_in = P_LOAD;
               end else begin
                  emit_in  = emit_ff + AW'(1);
                  phase_in = P_EMIT_RD;
               end
            end
         end
         default: begin
            phase_in = P_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_ff      <= emit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = DW'(rsp_value_ff);
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_truncated    = rsp_trunc_ff;

endmodule

FILE: rtl/core/ias_ram.sv
// ----------------------------------------------------------------------------
// ias_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ias_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/ias_qsort.sv
// ----------------------------------------------------------------------------
// ias_qsort
// In-place quicksort sequencer over the element memory, with a range stack.
// ----------------------------------------------------------------------------
module ias_qsort (
   input  logic                  clock,
   input  logic                  reset,
   input  ias_pkg::sort_cmd_type sort_cmd,
   output logic                  sort_done,
   output ias_pkg::mem_req_type  mem_req,
   input  ias_pkg::elem_type     mem_rdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_POP  = 4'd1;
   localparam logic [3:0] S_POPW = 4'd2;
   localparam logic [3:0] S_PIV  = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_SWR  = 4'd5;
   localparam logic [3:0] S_SW2  = 4'd6;
   localparam logic [3:0] S_FIN1 = 4'd7;
   localparam logic [3:0] S_FIN2 = 4'd8;
   localparam logic [3:0] S_FIN3 = 4'd9;
   localparam logic [3:0] S_FIN4 = 4'd10;

   localparam int AW = ias_pkg::ADDR_WIDTH;
   localparam int CW = ias_pkg::COUNT_WIDTH;
   localparam int RW = ias_pkg::RANGE_WIDTH;

   logic [3:0]          state_ff, state_in;
   ias_pkg::count_type  sp_ff, sp_in;
   ias_pkg::addr_type   lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in, k_ff, k_in;
   ias_pkg::elem_type   pivot_ff, pivot_in, ak_ff, ak_in;

   logic                stk_we;
   ias_pkg::addr_type   stk_waddr, stk_raddr;
   logic [RW-1:0]       stk_wdata, stk_rdata;

   logic                stk_room;

   ias_ram #(
      .DEPTH(ias_pkg::STORE_DEPTH),
      .WIDTH(RW)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign stk_room = (sp_ff < CW'(ias_pkg::STORE_DEPTH));

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      pivot_in  = pivot_ff;
      ak_in     = ak_ff;
      sort_done = 1'b0;
      mem_req   = '0;
      stk_we    = 1'b0;
      stk_waddr = sp_ff[AW-1:0];
      stk_wdata = '0;
      stk_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (sort_cmd.start) begin
               if (sort_cmd.count < CW'(2)) begin
                  sort_done = 1'b1;
               end else begin
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = {AW'(0), AW'(sort_cmd.count - CW'(1))};
                  sp_in     = CW'(1);
                  state_in  = S_POP;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               sort_done = 1'b1;
               state_in  = S_IDLE;
            end else begin
               stk_raddr = AW'(sp_ff - CW'(1));
               sp_in     = sp_ff - CW'(1);
               state_in  = S_POPW;
            end
         end
         S_POPW: begin
            lo_in = stk_rdata[RW-1:AW];
            hi_in = stk_rdata[AW-1:0];
            if (stk_rdata[RW-1:AW] >= stk_rdata[AW-1:0]) begin
               state_in = S_POP;
            end else begin
               mem_req.raddr = stk_rdata[RW-1:AW];
               state_in      = S_PIV;
            end
         end
         S_PIV: begin
            // The pivot entry stays untouched until the final exchange.
            pivot_in      = mem_rdata;
            i_in          = lo_ff;
            k_in          = lo_ff + AW'(1);
            mem_req.raddr = lo_ff + AW'(1);
            state_in      = S_CMP;
         end
         S_CMP: begin
            ak_in = mem_rdata;
            if (mem_rdata <= pivot_ff) begin
               i_in          = i_ff + AW'(1);
               mem_req.raddr = i_ff + AW'(1);
               state_in      = S_SWR;
            end else if (k_ff == hi_ff) begin
               state_in = S_FIN1;
            end else begin
               k_in          = k_ff + AW'(1);
               mem_req.raddr = k_ff + AW'(1);
            end
         end
         S_SWR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = k_ff;
            mem_req.wdata = mem_rdata;
            state_in      = S_SW2;
         end
         S_SW2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = i_ff;
            mem_req.wdata = ak_ff;
            if (k_ff == hi_ff) begin
               state_in = S_FIN1;
            end else begin
               k_in          = k_ff + AW'(1);
               mem_req.raddr = k_ff + AW'(1);
               state_in      = S_CMP;
            end
         end
         S_FIN1: begin
            mem_req.raddr = i_ff;
            state_in      = S_FIN2;
         end
         S_FIN2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = lo_ff;
            mem_req.wdata = mem_rdata;
            state_in      = S_FIN3;
         end
         S_FIN3: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = i_ff;
            mem_req.wdata = pivot_ff;
            // Right part first, so the left part is sorted next.
            if (({1'b0, i_ff} + CW'(1) < {1'b0, hi_ff}) && stk_room) begin
               stk_we    = 1'b1;
               stk_wdata = {i_ff + AW'(1), hi_ff};
               sp_in     = sp_ff + CW'(1);
            end
            state_in = S_FIN4;
         end
         S_FIN4: begin
            if (({1'b0, lo_ff} + CW'(1) < {1'b0, i_ff}) && stk_room) begin
               stk_we    = 1'b1;
               stk_wdata = {lo_ff, i_ff - AW'(1)};
               sp_in     = sp_ff + CW'(1);
            end
            state_in = S_POP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      k_ff     <= k_in;
      pivot_ff <= pivot_in;
      ak_ff    <= ak_in;
   end

endmodule

FILE: tb/sv/integer_array_sort_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_array_sort_tb
// Self-checking bench for the batch sorter of signed integers.
// ----------------------------------------------------------------------------
// Batches of signed values are sent with a last mark on the final request.
// An in-bench sorter keeps its own copy of the pending batch and queues the
// ascending order it expects, with the truncation flag, for each batch. The
// result stream is compared field by field with that queue. A short table of
// directed batches comes first, then random batches of mostly small sizes
// with a few that reach or pass the store capacity, under three patterns of
// idling and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module integer_array_sort_tb;

   localparam int DIRECTED_COUNT = 24;
   localparam int PHASE_ITEMS    = 100;
   localparam int HOLD_CYCLES    = 500;
   localparam int DRAIN_CYCLES   = 200;
   localparam int CYCLE_LIMIT    = 500000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_item;
      logic               typed;       // expectation written out in the row
      logic signed [31:0] exp_value;
      logic               exp_trunc;
   } directed_row_type;

   typedef struct {
      logic signed [31:0] sorted_value;
      logic               last_result;
      logic               truncated;
   } sorted_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_value;
   logic               req_last_item;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_sorted_value;
   logic               rsp_last_result;
   logic               rsp_truncated;

   directed_row_type    directed_rows [DIRECTED_COUNT];
   sorted_result_type   expected_sorted [$];
   sorted_result_type   oldest;
   ias_pkg::elem_type   batch_values [$];
   logic                batch_overflow;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   logic                hold_request;
   logic                hold_done;
   int                  mismatch_count;
   int                  cycle_count;
   int                  phase_items;

   integer_array_sort dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_truncated    (rsp_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Tracks the batch being loaded; on a last request it queues the whole batch
   // in ascending order. Requests beyond capacity only mark the batch truncated.
   task automatic absorb_request(input logic signed [31:0] value, input logic last_item,
                                 input logic typed, input logic signed [31:0] exp_value,
                                 input logic exp_trunc);
      ias_pkg::elem_type ordered [$];
      ias_pkg::elem_type key;
      sorted_result_type entry;
      int                i;
      int                j;
      if (batch_values.size() < ias_pkg::CAPACITY)
         batch_values.push_back(ias_pkg::elem_type'(value));
      else
         batch_overflow = 1'b1;
      if (last_item) begin
         if (typed) begin
            entry.sorted_value = exp_value;
            entry.last_result  = 1'b1;
            entry.truncated    = exp_trunc;
            expected_sorted.push_back(entry);
         end else begin
            ordered = batch_values;
            for (i = 1; i < ordered.size(); i++) begin
               key = ordered[i];
               j   = i - 1;
               while (j >= 0 && ordered[j] > key) begin
                  ordered[j + 1] = ordered[j];
                  j--;
               end
               ordered[j + 1] = key;
            end
            for (i = 0; i < ordered.size(); i++) begin
               entry.sorted_value = ordered[i];
               entry.last_result  = (i == ordered.size() - 1);
               entry.truncated    = batch_overflow;
               expected_sorted.push_back(entry);
            end
         end
         batch_values.delete();
         batch_overflow = 1'b0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic signed [31:0] value, input logic last_item,
                               input logic typed, input logic signed [31:0] exp_value,
                               input logic exp_trunc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid     = 1'b0;
         req_value     = $urandom;
         req_last_item = 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_value     = value;
      req_last_item = last_item;
      do @(posedge clock); while (!req_ready);
      absorb_request(value, last_item, typed, exp_value, exp_trunc);
      phase_items++;
      @(negedge clock);
   endtask

   // Orders: 0 random, 1 rising, 2 falling, 3 all equal.
   task automatic send_batch(input int size, input int order);
      logic signed [31:0] base;
      logic signed [31:0] stride;
      logic signed [31:0] value;
      int                 k;
      base   = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 2000)) - 1000;
      stride = $urandom_range(1, 1000);
      for (k = 0; k < size; k++) begin
         case (order)
            1: value = base + k * stride;
            2: value = base - k * stride;
            3: value = base;
            default: begin
               case ($urandom_range(0, 7))
                  0, 1: value = $signed($urandom_range(0, 15)) - 8;
                  2: value = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                  default: value = $urandom;
               endcase
            end
         endcase
         send_request(value, k == size - 1, 1'b0, '0, 1'b0);
      end
   endtask

   task automatic run_random_batches();
      while (phase_items < PHASE_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            send_batch($urandom_range(60, 70), $urandom_range(0, 3));
         else
            send_batch($urandom_range(1, 12), $urandom_range(0, 3));
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sorted.size() == 0) begin
            $error("unexpected result: sorted_value %0d, last_result %0b, truncated %0b",
                   rsp_sorted_value, rsp_last_result, rsp_truncated);
            mismatch_count++;
         end else begin
            oldest = expected_sorted.pop_front();
            if (rsp_sorted_value !== oldest.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      oldest.sorted_value, rsp_sorted_value);
               mismatch_count++;
            end
            if (rsp_last_result !== oldest.last_result) begin
               $error("last_result: expected %0b, got %0b",
                      oldest.last_result, rsp_last_result);
               mismatch_count++;
            end
            if (rsp_truncated !== oldest.truncated) begin
               $error("truncated: expected %0b, got %0b", oldest.truncated, rsp_truncated);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int r;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      req_last_item  = 1'b0;
      hold_request   = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      phase_items    = 0;
      batch_overflow = 1'b0;
      send_idle_pct  = 29;
      recv_idle_pct  = 60;

      // Single-value batches come straight back; the rest go through the sorter.
      directed_rows = '{
         '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b0},
         '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b0},
         '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000, 1'b0},
         '{32'shffff_ffff, 1'b1, 1'b1, 32'shffff_ffff, 1'b0},
         '{32'sh7fff_ffff, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sh8000_0000, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sh0000_0000, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'shffff_ffff, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sh0000_0001, 1'b1, 1'b0, 32'sh0, 1'b0},
         '{32'sh0000_0005, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sh0000_0005, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sh0000_0005, 1'b1, 1'b0, 32'sh0, 1'b0},
         '{-32'sd3,        1'b0, 1'b0, 32'sh0, 1'b0},
         '{-32'sd2,        1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sd10,        1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sd20,        1'b1, 1'b0, 32'sh0, 1'b0},
         '{32'sd40,        1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sd30,        1'b0, 1'b0, 32'sh0, 1'b0},
         '{-32'sd30,       1'b0, 1'b0, 32'sh0, 1'b0},
         '{-32'sd40,       1'b1, 1'b0, 32'sh0, 1'b0},
         '{32'sd1,         1'b0, 1'b0, 32'sh0, 1'b0},
         '{-32'sd1,        1'b1, 1'b0, 32'sh0, 1'b0},
         '{32'shaaaa_aaaa, 1'b0, 1'b0, 32'sh0, 1'b0},
         '{32'sh5555_5555, 1'b1, 1'b0, 32'sh0, 1'b0}
      };

      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < DIRECTED_COUNT; r++) begin
         send_request(directed_rows[r].value, directed_rows[r].last_item,
                      directed_rows[r].typed, directed_rows[r].exp_value,
                      directed_rows[r].exp_trunc);
      end

      // A batch that fills the store exactly; the next phase opens with one whose
      // last request is dropped for capacity but still starts the sort.
      phase_items = 0;
      send_batch(ias_pkg::CAPACITY, 0);
      run_random_batches();

      send_idle_pct = 60;
      recv_idle_pct = 29;
      phase_items   = 0;
      send_batch(ias_pkg::CAPACITY + 1, 2);
      run_random_batches();

      // The result side stops for a long stretch so the block fills and
      // back-pressures its input while requests keep coming.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      phase_items   = 0;
      hold_request  = 1'b1;
      repeat (6) send_batch(4, 0);
      run_random_batches();

      req_valid = 1'b0;
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/ias_pkg.sv
rtl/core/ias_ram.sv
rtl/core/ias_qsort.sv
rtl/core/integer_array_sort.sv
tb/sv/integer_array_sort_tb.sv
